@@ sv/rrfa_pkg.sv @@
// rrfa_pkg: shared constants, codes and controller/datapath handshake types
`default_nettype none

package rrfa_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int OFFSET_BITS_DEF = 40;
	localparam int CHUNK_BYTES     = (8 << 10);
	localparam int OP_W            = 2;
	localparam int ID_W            = 8;
	localparam int AHEAD_W         = 32;
	localparam int STATUS_W        = 3;
	localparam int COUNT_OUT_W     = 4;

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 2'd0,
		OP_FORGET  = 2'd1,
		OP_PICK    = 2'd2,
		OP_REPORT  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_BUSY    = 3'd3,
		ST_NO_WORK = 3'd4
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} dp_cmd_t;

	// status from the datapath back to the controller
	typedef struct packed {
		logic early;
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ sv/rrfa_req_if.sv @@
// rrfa_req_if: request channel carrying one scheduler operation per word
`default_nettype none

interface rrfa_req_if #(
	parameter int OFFSET_BITS = rrfa_pkg::OFFSET_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [rrfa_pkg::OP_W-1:0]    operation;
	logic [rrfa_pkg::ID_W-1:0]    buffer_id;
	logic [OFFSET_BITS-1:0]       offset;
	logic                         fill_done;

	modport source (output valid, operation, buffer_id, offset, fill_done, input ready);
	modport sink   (input valid, operation, buffer_id, offset, fill_done, output ready);
endinterface

`default_nettype wire

@@ sv/rrfa_rsp_if.sv @@
// rrfa_rsp_if: response channel carrying one result word per request
`default_nettype none

interface rrfa_rsp_if #(
	parameter int OFFSET_BITS = rrfa_pkg::OFFSET_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic [rrfa_pkg::STATUS_W-1:0]    status;
	logic [rrfa_pkg::ID_W-1:0]        work_id;
	logic [OFFSET_BITS:0]             fill_target;
	logic                             requeued;
	logic [rrfa_pkg::COUNT_OUT_W-1:0] queue_count;

	modport source (output valid, status, work_id, fill_target, requeued, queue_count,
		input ready);
	modport sink   (input valid, status, work_id, fill_target, requeued, queue_count,
		output ready);
endinterface

`default_nettype wire

@@ sv/rrfa_cfg_if.sv @@
// rrfa_cfg_if: configuration write channel for the look-ahead register
`default_nettype none

interface rrfa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rrfa_pkg::AHEAD_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ sv/rrfa_ram.sv @@
// rrfa_ram: generic single write port, single read port ram with registered read
`default_nettype none

module rrfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

`default_nettype wire

@@ sv/rrfa_ctrl.sv @@
// rrfa_ctrl: sequencing state machine, accept / scan queue / commit result
`default_nettype none

module rrfa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output      logic              req_ready,
	input  wire rrfa_pkg::dp_sts_t sts,
	output      rrfa_pkg::dp_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.early || sts.scan_done) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				// wait until the result register can take the word
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule

`default_nettype wire

@@ sv/rrfa_dp.sv @@
// rrfa_dp: queue memory, scan pointers, work registers and result register
`default_nettype none

module rrfa_dp #(
	parameter int QUEUE_DEPTH = rrfa_pkg::QUEUE_DEPTH_DEF,
	parameter int OFFSET_BITS = rrfa_pkg::OFFSET_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rrfa_req_if.sink               req,
	rrfa_rsp_if.source             rsp,
	rrfa_cfg_if.sink               cfg,
	input  wire rrfa_pkg::dp_cmd_t cmd,
	output      rrfa_pkg::dp_sts_t sts
);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int GW = OFFSET_BITS + 1;
	localparam int SW = (GW > rrfa_pkg::AHEAD_W + 1) ? GW : rrfa_pkg::AHEAD_W + 1;
	localparam int EW = rrfa_pkg::ID_W + GW;

	// latched request
	rrfa_pkg::op_t                op_q;
	logic [rrfa_pkg::ID_W-1:0]    id_q;
	logic [OFFSET_BITS-1:0]       off_q;
	logic                         done_q;

	// queue bookkeeping and scan pointers
	logic [CW-1:0]                cnt_q, cnt_nxt;
	logic [CW-1:0]                rd_q, wr_q;
	logic [IW-1:0]                rk_q;
	logic                         rv_q, found_q;
	logic [rrfa_pkg::ID_W-1:0]    front_id_q;
	logic [GW-1:0]                front_goal_q;

	// current work and configuration
	logic                         work_active_q;
	logic [rrfa_pkg::ID_W-1:0]    work_buf_q;
	logic [GW-1:0]                work_goal_q;
	logic [rrfa_pkg::AHEAD_W-1:0] ahead_q;

	// result register
	logic                         out_valid_q;
	rrfa_pkg::status_t            status_q, status_nxt;
	logic [rrfa_pkg::ID_W-1:0]    wid_q, wid_nxt;
	logic [GW-1:0]                tgt_q, tgt_nxt;
	logic                         rq_q, rq_nxt;
	logic [rrfa_pkg::COUNT_OUT_W-1:0] qcnt_q;
	logic [CW+rrfa_pkg::COUNT_OUT_W-1:0] cnt_ext;

	// memory port
	logic                         we, re;
	logic [IW-1:0]                waddr;
	logic [EW-1:0]                wdata, rdata;

	logic [rrfa_pkg::ID_W-1:0]    rid;
	logic [GW-1:0]                rgoal;
	logic [SW-1:0]                goal_sum;
	logic [GW-1:0]                goal_in;
	rrfa_pkg::status_t            early_st;
	logic                         early, step, wr_inc, found_set, complete;

	rrfa_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (rd_q[IW-1:0]),
		.rdata (rdata)
	);

	assign rid      = rdata[EW-1:GW];
	assign rgoal    = rdata[GW-1:0];
	assign goal_sum = SW'(off_q) + SW'(ahead_q);
	assign goal_in  = goal_sum[GW-1:0];
	assign complete = done_q || (GW'(off_q) >= work_goal_q);

	// operations that resolve without touching the queue
	always_comb begin
		early_st = rrfa_pkg::ST_OK;
		unique case (op_q)
			rrfa_pkg::OP_ENQUEUE: early_st = rrfa_pkg::ST_OK;
			rrfa_pkg::OP_FORGET: begin
				if (work_active_q && work_buf_q == id_q) early_st = rrfa_pkg::ST_BUSY;
			end
			rrfa_pkg::OP_PICK: begin
				if (work_active_q) early_st = rrfa_pkg::ST_BUSY;
				else if (cnt_q == '0) early_st = rrfa_pkg::ST_EMPTY;
			end
			rrfa_pkg::OP_REPORT: begin
				if (!work_active_q || cnt_q == '0) early_st = rrfa_pkg::ST_NO_WORK;
			end
			default: early_st = rrfa_pkg::ST_OK;
		endcase
	end

	assign early = (early_st != rrfa_pkg::ST_OK);
	assign step  = cmd.scan && !early;
	assign re    = step && (rd_q != cnt_q);

	always_comb begin
		we         = 1'b0;
		waddr      = '0;
		wdata      = rdata;
		wr_inc     = 1'b0;
		found_set  = 1'b0;
		cnt_nxt    = cnt_q;
		status_nxt = early_st;
		wid_nxt    = '0;
		tgt_nxt    = '0;
		rq_nxt     = 1'b0;

		// scan: one entry arrives per cycle, filtered or updated in place
		if (step && rv_q) begin
			case (op_q)
				rrfa_pkg::OP_ENQUEUE: begin
					if (!found_q && rid == id_q) begin
						we        = 1'b1;
						waddr     = rk_q;
						wdata     = {id_q, goal_in};
						found_set = 1'b1;
					end
				end
				rrfa_pkg::OP_FORGET: begin
					if (rid != id_q) begin
						we     = 1'b1;
						waddr  = wr_q[IW-1:0];
						wr_inc = 1'b1;
					end
				end
				rrfa_pkg::OP_REPORT: begin
					if (rk_q != '0) begin
						we     = 1'b1;
						waddr  = wr_q[IW-1:0];
						wr_inc = 1'b1;
					end
				end
				default: ;
			endcase
		end

		// commit
		if (cmd.finish) begin
			if (early) begin
				if (op_q == rrfa_pkg::OP_PICK && early_st == rrfa_pkg::ST_BUSY) begin
					wid_nxt = work_buf_q;
				end
			end else begin
				case (op_q)
					rrfa_pkg::OP_ENQUEUE: begin
						if (!found_q) begin
							if (cnt_q == CW'(QUEUE_DEPTH)) begin
								status_nxt = rrfa_pkg::ST_FULL;
							end else begin
								we      = 1'b1;
								waddr   = cnt_q[IW-1:0];
								wdata   = {id_q, goal_in};
								cnt_nxt = cnt_q + CW'(1);
							end
						end
					end
					rrfa_pkg::OP_FORGET: begin
						cnt_nxt = wr_q;
					end
					rrfa_pkg::OP_PICK: begin
						wid_nxt = front_id_q;
						tgt_nxt = GW'(off_q) + GW'(rrfa_pkg::CHUNK_BYTES);
					end
					default: begin
						wid_nxt = work_buf_q;
						if (!complete) begin
							we     = 1'b1;
							waddr  = wr_q[IW-1:0];
							wdata  = {front_id_q, front_goal_q};
							rq_nxt = 1'b1;
						end else begin
							cnt_nxt = wr_q;
						end
					end
				endcase
			end
		end
	end

	assign cnt_ext = (CW + rrfa_pkg::COUNT_OUT_W)'(cnt_nxt);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= rrfa_pkg::op_t'(req.operation);
			id_q   <= req.buffer_id;
			off_q  <= req.offset;
			done_q <= req.fill_done;
		end
		if (step && rv_q && rk_q == '0) begin
			front_id_q   <= rid;
			front_goal_q <= rgoal;
		end
		if (cmd.finish) begin
			status_q <= status_nxt;
			wid_q    <= wid_nxt;
			tgt_q    <= tgt_nxt;
			rq_q     <= rq_nxt;
			qcnt_q   <= cnt_ext[rrfa_pkg::COUNT_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			rd_q          <= '0;
			wr_q          <= '0;
			rk_q          <= '0;
			rv_q          <= 1'b0;
			found_q       <= 1'b0;
			work_active_q <= 1'b0;
			work_buf_q    <= '0;
			work_goal_q   <= '0;
			ahead_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				ahead_q <= cfg.data;
			end
			if (cmd.load) begin
				rd_q    <= '0;
				wr_q    <= '0;
				rv_q    <= 1'b0;
				found_q <= 1'b0;
			end else if (step) begin
				rv_q <= re;
				rk_q <= rd_q[IW-1:0];
				if (re) rd_q <= rd_q + CW'(1);
				if (wr_inc) wr_q <= wr_q + CW'(1);
				if (found_set) found_q <= 1'b1;
			end
			if (cmd.finish) begin
				cnt_q <= cnt_nxt;
				if (!early && op_q == rrfa_pkg::OP_PICK) begin
					work_active_q <= 1'b1;
					work_buf_q    <= front_id_q;
					work_goal_q   <= front_goal_q;
				end
				if (!early && op_q == rrfa_pkg::OP_REPORT) begin
					work_active_q <= 1'b0;
					work_buf_q    <= '0;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.early     = early;
	assign sts.scan_done = !rv_q && (rd_q == cnt_q);
	assign sts.out_free  = !out_valid_q || rsp.ready;

	assign cfg.ready       = 1'b1;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.work_id     = wid_q;
	assign rsp.fill_target = tgt_q;
	assign rsp.requeued    = rq_q;
	assign rsp.queue_count = qcnt_q;
endmodule

`default_nettype wire

@@ sv/round_robin_fill_ahead_scheduler.sv @@
// round_robin_fill_ahead_scheduler: top level of the fill-ahead work queue
//
// usage
// - req carries one operation word: enqueue (goal = offset + look-ahead),
//   forget, pick next work (target = file size + 8 KiB) or report a chunk
// - rsp returns exactly one word per request: status, work id, fill target,
//   requeued flag and the queue occupancy after the operation
// - cfg writes the 32-bit look-ahead; write it only while no request is open
// - a request is accepted while idle, then the queue memory is walked, which
//   reads one entry per cycle through its single read port, and then the result
//   is committed into the response register; an empty queue or a word answered
//   without a queue walk (busy, empty, no current work) needs no memory reads
// - throughput: one request at a time, the next taken only after the last commits
// - the next request is taken as soon as the response word is registered,
//   even if the receiver has not yet taken it
// - receiver stall: the response register holds; a following request is
//   processed but waits in its commit step until the register frees
// - reset: queue empty, no current work, look-ahead zero, no response pending
`default_nettype none

module round_robin_fill_ahead_scheduler #(
	parameter int QUEUE_DEPTH = rrfa_pkg::QUEUE_DEPTH_DEF,
	parameter int OFFSET_BITS = rrfa_pkg::OFFSET_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rrfa_req_if.sink   req,
	rrfa_rsp_if.source rsp,
	rrfa_cfg_if.sink   cfg
);
	rrfa_pkg::dp_cmd_t cmd;
	rrfa_pkg::dp_sts_t sts;
	logic              in_ready;

	// sequencer: idle, walk the queue, commit into the response register
	rrfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	assign req.ready = in_ready;

	// queue memory, pointers, current work and response register
	rrfa_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

	// a request is worked on alone: no new word right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous one in flight");

	// rotation is only reported on a successful report
	a_requeue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.requeued |-> rsp.status == rrfa_pkg::ST_OK)
		else $error("requeued flag with non-ok status");

	// a fill target only comes with a successful pick
	a_target_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.fill_target != '0 |-> rsp.status == rrfa_pkg::ST_OK)
		else $error("fill target with non-ok status");
endmodule

`default_nettype wire
